FILE: sv/kpar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kpar_pkg;

	localparam int BUTTON_COUNT = 4;
	localparam int CNT_W        = 16;
	localparam int PER_W        = 10;
	localparam int CODE_W       = 3;
	localparam int TENTHS_W     = 14;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// hold / 5 as a reciprocal multiply: exact for any 16-bit count
	localparam logic [31:0] DIV5_MUL   = 32'd52429;
	localparam int          DIV5_SHIFT = 18;

	localparam logic [CODE_W-1:0] KEY_NONE    = 3'd0;
	localparam logic [CODE_W-1:0] KEY_ONE     = 3'd1;
	localparam logic [CODE_W-1:0] KEY_TWO     = 3'd2;
	localparam logic [CODE_W-1:0] KEY_THREE   = 3'd3;
	localparam logic [CODE_W-1:0] KEY_FOUR    = 3'd4;
	localparam logic [CODE_W-1:0] KEY_FIVE    = 3'd5;
	localparam logic [CODE_W-1:0] KEY_INVALID = 3'd6;

	localparam logic [PER_W-1:0] PER_800 = 10'd800;
	localparam logic [PER_W-1:0] PER_600 = 10'd600;
	localparam logic [PER_W-1:0] PER_400 = 10'd400;
	localparam logic [PER_W-1:0] PER_200 = 10'd200;
	localparam logic [PER_W-1:0] PER_100 = 10'd100;
	localparam logic [PER_W-1:0] PER_80  = 10'd80;
	localparam logic [PER_W-1:0] PER_20  = 10'd20;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_THR_ONE  = 3'd1;
	localparam logic [2:0] REG_THR_TWO  = 3'd2;
	localparam logic [2:0] REG_THR_THREE = 3'd3;
	localparam logic [2:0] REG_THR_FOUR = 3'd4;
	localparam logic [2:0] REG_THR_FIVE = 3'd5;
	localparam logic [2:0] REG_THR_SIX  = 3'd6;

	typedef struct packed {
		logic [7:0] debounce_count;
		logic [7:0] threshold_one;
		logic [7:0] threshold_two;
		logic [7:0] threshold_three;
		logic [7:0] threshold_four;
		logic [7:0] threshold_five;
		logic [7:0] threshold_six;
	} kpar_cfg_t;

	function automatic logic [CODE_W-1:0] decode_buttons(input logic [BUTTON_COUNT-1:0] bits);
		logic [CODE_W-1:0] code;
		case (bits)
			4'h0:    code = KEY_NONE;
			4'h8:    code = KEY_ONE;
			4'h4:    code = KEY_TWO;
			4'h1:    code = KEY_THREE;
			4'h2:    code = KEY_FOUR;
			4'h3:    code = KEY_FIVE;
			default: code = KEY_INVALID;
		endcase
		return code;
	endfunction

	function automatic logic [PER_W-1:0] choose_period(input logic [CNT_W-1:0] c,
			input kpar_cfg_t cfg);
		logic [PER_W-1:0] per;
		if (c < {{(CNT_W-8){1'b0}}, cfg.threshold_one})
			per = PER_800;
		else if (c < {{(CNT_W-8){1'b0}}, cfg.threshold_two})
			per = PER_600;
		else if (c < {{(CNT_W-8){1'b0}}, cfg.threshold_three})
			per = PER_400;
		else if (c < {{(CNT_W-8){1'b0}}, cfg.threshold_four})
			per = PER_200;
		else if (c < {{(CNT_W-8){1'b0}}, cfg.threshold_five})
			per = PER_100;
		else if (c < {{(CNT_W-8){1'b0}}, cfg.threshold_six})
			per = PER_80;
		else
			per = PER_20;
		return per;
	endfunction

endpackage

`default_nettype wire

FILE: sv/kpar_track.sv
`timescale 1ns / 1ps
`default_nettype none

// Key tracking state: previous key, hold counter and repeat period.
// State moves only when adv is high; outputs show the values for this tick.
module kpar_track (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 adv,
	input  wire  [kpar_pkg::BUTTON_COUNT-1:0]   bits,
	input  wire  kpar_pkg::kpar_cfg_t           cfg,
	output logic [kpar_pkg::CODE_W-1:0]         code,
	output logic                                shot,
	output logic [kpar_pkg::PER_W-1:0]          period,
	output logic [kpar_pkg::CNT_W-1:0]          hold
);

	logic [kpar_pkg::CODE_W-1:0] prev_key_q;
	logic [kpar_pkg::CNT_W-1:0]  cnt_q;
	logic [kpar_pkg::PER_W-1:0]  per_q;
	logic [kpar_pkg::CNT_W-1:0]  cnt_inc;

	assign code    = kpar_pkg::decode_buttons(bits);
	assign cnt_inc = (cnt_q == kpar_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		hold   = cnt_q;
		period = per_q;
		shot   = 1'b0;
		if (code == kpar_pkg::KEY_NONE || code == kpar_pkg::KEY_INVALID) begin
			hold = '0;
		end else if (code == prev_key_q) begin
			hold = cnt_inc;
			if (cnt_inc > {{(kpar_pkg::CNT_W-8){1'b0}}, cfg.debounce_count})
				period = kpar_pkg::choose_period(cnt_inc, cfg);
		end else begin
			hold = '0;
			shot = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q <= kpar_pkg::KEY_NONE;
			cnt_q      <= '0;
			per_q      <= '0;
		end else if (adv) begin
			prev_key_q <= code;
			cnt_q      <= hold;
			per_q      <= period;
		end
	end

endmodule

`default_nettype wire

FILE: sv/keypad_autorepeat_accel.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake                | Payload
// ---------+--------------------------+-----------------------------------------------
// in       | in_valid / in_stall      | button_bits
// out      | out_valid / out_stall    | key_code, one_shot, repeat_period_ms,
//          |                          | hold_ticks, hold_tenths
// cfg      | APB psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// From input transfer to result: input register, then result register.
// One tick is taken every clock while the output side keeps up.
// The key state updates as the tick moves into the result register, so a
// stalled result holds both stages; in_stall rises only when the input register is full.
// Reset clears the key state and loads the register defaults; no clearing pass.
module keypad_autorepeat_accel (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [kpar_pkg::BUTTON_COUNT-1:0]     button_bits,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [kpar_pkg::CODE_W-1:0]           key_code,
	output logic                                  one_shot,
	output logic [kpar_pkg::PER_W-1:0]            repeat_period_ms,
	output logic [15:0]                           hold_ticks,
	output logic [kpar_pkg::TENTHS_W-1:0]         hold_tenths,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [kpar_pkg::ADDR_W-1:0]           paddr,
	input  wire  [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	kpar_pkg::kpar_cfg_t cfg_q;

	logic [kpar_pkg::BUTTON_COUNT-1:0] bits_s1;
	logic                              valid_s1;

	logic                              valid_s2;
	logic [kpar_pkg::CODE_W-1:0]       code_s2;
	logic                              shot_s2;
	logic [kpar_pkg::PER_W-1:0]        per_s2;
	logic [kpar_pkg::CNT_W-1:0]        hold_s2;

	logic                              adv;
	logic                              cfg_wr;
	logic [2:0]                        reg_idx;
	logic [kpar_pkg::CODE_W-1:0]       code_c;
	logic                              shot_c;
	logic [kpar_pkg::PER_W-1:0]        per_c;
	logic [kpar_pkg::CNT_W-1:0]        hold_c;
	logic [31:0]                       tenths_prod;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count  <= 8'd1;
			cfg_q.threshold_one   <= 8'd30;
			cfg_q.threshold_two   <= 8'd60;
			cfg_q.threshold_three <= 8'd90;
			cfg_q.threshold_four  <= 8'd120;
			cfg_q.threshold_five  <= 8'd150;
			cfg_q.threshold_six   <= 8'd250;
		end else if (cfg_wr) begin
			case (reg_idx)
				kpar_pkg::REG_DEBOUNCE:  cfg_q.debounce_count  <= pwdata[7:0];
				kpar_pkg::REG_THR_ONE:   cfg_q.threshold_one   <= pwdata[7:0];
				kpar_pkg::REG_THR_TWO:   cfg_q.threshold_two   <= pwdata[7:0];
				kpar_pkg::REG_THR_THREE: cfg_q.threshold_three <= pwdata[7:0];
				kpar_pkg::REG_THR_FOUR:  cfg_q.threshold_four  <= pwdata[7:0];
				kpar_pkg::REG_THR_FIVE:  cfg_q.threshold_five  <= pwdata[7:0];
				kpar_pkg::REG_THR_SIX:   cfg_q.threshold_six   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			kpar_pkg::REG_DEBOUNCE:  prdata = {24'd0, cfg_q.debounce_count};
			kpar_pkg::REG_THR_ONE:   prdata = {24'd0, cfg_q.threshold_one};
			kpar_pkg::REG_THR_TWO:   prdata = {24'd0, cfg_q.threshold_two};
			kpar_pkg::REG_THR_THREE: prdata = {24'd0, cfg_q.threshold_three};
			kpar_pkg::REG_THR_FOUR:  prdata = {24'd0, cfg_q.threshold_four};
			kpar_pkg::REG_THR_FIVE:  prdata = {24'd0, cfg_q.threshold_five};
			kpar_pkg::REG_THR_SIX:   prdata = {24'd0, cfg_q.threshold_six};
			default:                 prdata = 32'd0;
		endcase
	end

	// pipeline control
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			bits_s1 <= button_bits;
	end

	kpar_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.bits   (bits_s1),
		.cfg    (cfg_q),
		.code   (code_c),
		.shot   (shot_c),
		.period (per_c),
		.hold   (hold_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_s2 <= code_c;
			shot_s2 <= shot_c;
			per_s2  <= per_c;
			hold_s2 <= hold_c;
		end
	end

	assign tenths_prod = {{(32-kpar_pkg::CNT_W){1'b0}}, hold_s2} * kpar_pkg::DIV5_MUL;

	assign out_valid        = valid_s2;
	assign key_code         = code_s2;
	assign one_shot         = shot_s2;
	assign repeat_period_ms = per_s2;
	assign hold_ticks       = hold_s2[15:0];
	assign hold_tenths      = tenths_prod[kpar_pkg::DIV5_SHIFT +: kpar_pkg::TENTHS_W];

endmodule

`default_nettype wire

FILE: verif/keypad_autorepeat_accel_test.sv
`timescale 1ns / 1ps

module keypad_autorepeat_accel_test;

	localparam int REG_UNUSED = 7;        // decodes to no register
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 265;       // past the largest debounce count

	typedef struct packed {
		logic [kpar_pkg::CODE_W-1:0]   code;
		logic                          shot;
		logic [kpar_pkg::PER_W-1:0]    period;
		logic [15:0]                   held;
		logic [kpar_pkg::TENTHS_W-1:0] tenths;
	} key_result_t;

	class key_scoreboard;
		kpar_pkg::kpar_cfg_t         cfg;
		logic [kpar_pkg::CODE_W-1:0] last_code;
		logic [kpar_pkg::CNT_W-1:0]  held;
		logic [kpar_pkg::PER_W-1:0]  period;
		key_result_t                 expected_q[$];
		int                          errors;

		function new();
			cfg.debounce_count  = 8'd1;
			cfg.threshold_one   = 8'd30;
			cfg.threshold_two   = 8'd60;
			cfg.threshold_three = 8'd90;
			cfg.threshold_four  = 8'd120;
			cfg.threshold_five  = 8'd150;
			cfg.threshold_six   = 8'd250;
			last_code = kpar_pkg::KEY_NONE;
			held = '0;
			period = '0;
			errors = 0;
		endfunction

		function void set_register(int idx, logic [7:0] v);
			case (idx)
				kpar_pkg::REG_DEBOUNCE:  cfg.debounce_count  = v;
				kpar_pkg::REG_THR_ONE:   cfg.threshold_one   = v;
				kpar_pkg::REG_THR_TWO:   cfg.threshold_two   = v;
				kpar_pkg::REG_THR_THREE: cfg.threshold_three = v;
				kpar_pkg::REG_THR_FOUR:  cfg.threshold_four  = v;
				kpar_pkg::REG_THR_FIVE:  cfg.threshold_five  = v;
				kpar_pkg::REG_THR_SIX:   cfg.threshold_six   = v;
				default: ;
			endcase
		endfunction

		function logic [kpar_pkg::CODE_W-1:0] key_of(logic [kpar_pkg::BUTTON_COUNT-1:0] bits);
			case (bits)
				4'h0:    return kpar_pkg::KEY_NONE;
				4'h8:    return kpar_pkg::KEY_ONE;
				4'h4:    return kpar_pkg::KEY_TWO;
				4'h1:    return kpar_pkg::KEY_THREE;
				4'h2:    return kpar_pkg::KEY_FOUR;
				4'h3:    return kpar_pkg::KEY_FIVE;
				default: return kpar_pkg::KEY_INVALID;
			endcase
		endfunction

		// plain priority chain, so out-of-order thresholds resolve top-down
		function logic [kpar_pkg::PER_W-1:0] repeat_for(logic [kpar_pkg::CNT_W-1:0] c);
			if (c < cfg.threshold_one)   return kpar_pkg::PER_800;
			if (c < cfg.threshold_two)   return kpar_pkg::PER_600;
			if (c < cfg.threshold_three) return kpar_pkg::PER_400;
			if (c < cfg.threshold_four)  return kpar_pkg::PER_200;
			if (c < cfg.threshold_five)  return kpar_pkg::PER_100;
			if (c < cfg.threshold_six)   return kpar_pkg::PER_80;
			return kpar_pkg::PER_20;
		endfunction

		function void note_tick(logic [kpar_pkg::BUTTON_COUNT-1:0] bits);
			key_result_t                 r;
			logic [kpar_pkg::CODE_W-1:0] code;
			code = key_of(bits);
			r.shot = 1'b0;
			if (code == kpar_pkg::KEY_NONE || code == kpar_pkg::KEY_INVALID) begin
				held = '0;
			end else if (code == last_code) begin
				if (held != kpar_pkg::CNT_MAX)
					held++;
				if (held > cfg.debounce_count)
					period = repeat_for(held);
			end else begin
				held = '0;
				r.shot = 1'b1;
			end
			last_code = code;
			r.code = code;
			r.period = period;
			r.held = held[15:0];
			r.tenths = kpar_pkg::TENTHS_W'(held / 5);
			expected_q.push_back(r);
		endfunction

		function void check_result(key_result_t got);
			key_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing pending: key_code %0d hold_ticks %0d",
					got.code, got.held);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.code !== want.code) begin
				$error("key_code expected %0d, got %0d", want.code, got.code);
				errors++;
			end
			if (got.shot !== want.shot) begin
				$error("one_shot expected %0d, got %0d", want.shot, got.shot);
				errors++;
			end
			if (got.period !== want.period) begin
				$error("repeat_period_ms expected %0d, got %0d", want.period, got.period);
				errors++;
			end
			if (got.held !== want.held) begin
				$error("hold_ticks expected %0d, got %0d", want.held, got.held);
				errors++;
			end
			if (got.tenths !== want.tenths) begin
				$error("hold_tenths expected %0d, got %0d", want.tenths, got.tenths);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic [kpar_pkg::BUTTON_COUNT-1:0]   button_bits;
	logic                                out_valid;
	logic                                out_stall;
	logic [kpar_pkg::CODE_W-1:0]         key_code;
	logic                                one_shot;
	logic [kpar_pkg::PER_W-1:0]          repeat_period_ms;
	logic [15:0]                         hold_ticks;
	logic [kpar_pkg::TENTHS_W-1:0]       hold_tenths;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [kpar_pkg::ADDR_W-1:0]         paddr;
	logic [31:0]                         pwdata;
	logic [31:0]                         prdata;
	logic                                pready;

	key_scoreboard sb = new();
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	bit            pressure_armed = 1'b0;
	bit            pressure_done = 1'b0;
	int            hold_off_left = 0;
	int            cycles = 0;

	keypad_autorepeat_accel dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .button_bits(button_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.key_code(key_code), .one_shot(one_shot), .repeat_period_ms(repeat_period_ms),
		.hold_ticks(hold_ticks), .hold_tenths(hold_tenths),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: one long hold-off when armed, random stalls otherwise
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				out_stall <= 1'b1;
				hold_off_left--;
			end else if (pressure_armed && !pressure_done) begin
				pressure_done = 1'b1;
				hold_off_left = 300;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// sample mid-cycle so the transfer at the next edge is known without races
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({key_code, one_shot, repeat_period_ms, hold_ticks, hold_tenths});
	end

	task automatic send_tick(input logic [kpar_pkg::BUTTON_COUNT-1:0] bits);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_bits <= bits;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sb.note_tick(bits);
	endtask

	task automatic write_reg(input int idx, input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= kpar_pkg::ADDR_W'(idx * 4);
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		sb.set_register(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input int sel);
		logic [7:0] v[7];
		int         step_max;
		case (sel)
			0: foreach (v[i]) v[i] = 8'd0;
			1: foreach (v[i]) v[i] = 8'hff;
			3, 7: foreach (v[i]) v[i] = 8'($urandom_range(255));
			4: v = '{8'd1, 8'd30, 8'd60, 8'd90, 8'd120, 8'd150, 8'd250};
			9: v = '{8'd255, 8'd30, 8'd60, 8'd90, 8'd120, 8'd150, 8'd250};
			default: begin
				// ascending thresholds; narrow steps for sel 2 and 6 so short holds walk the chain
				step_max = (sel == 2 || sel == 6) ? 10 : 40;
				v[0] = 8'($urandom_range(4));
				v[1] = 8'($urandom_range(1, step_max));
				for (int i = 2; i < 7; i++)
					v[i] = 8'(v[i-1] + $urandom_range(step_max));
			end
		endcase
		for (int i = 0; i < 7; i++)
			write_reg(i, v[i]);
		if (sel == 3)
			write_reg(REG_UNUSED, 8'($urandom_range(255)));
	endtask

	task automatic run_random(input int count);
		logic [kpar_pkg::BUTTON_COUNT-1:0] key_pats[5] = '{4'h8, 4'h4, 4'h1, 4'h2, 4'h3};
		logic [kpar_pkg::BUTTON_COUNT-1:0] pat;
		int                                sent = 0;
		int                                len;
		int                                roll;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				pat = key_pats[$urandom_range(4)];
				len = ($urandom_range(11) == 0) ? $urandom_range(60, 280) : $urandom_range(1, 40);
			end else if (roll < 85) begin
				pat = '0;
				len = $urandom_range(1, 4);
			end else begin
				len = 0;
				repeat ($urandom_range(1, 3)) begin
					send_tick(kpar_pkg::BUTTON_COUNT'($urandom_range(15)));
					sent++;
				end
			end
			repeat (len) send_tick(pat);
			sent += len;
		end
	endtask

	initial begin
		logic [kpar_pkg::BUTTON_COUNT-1:0] directed[25];
		int idle_send[3];
		int idle_recv[3];

		directed = '{
			4'h0, 4'h8, 4'h8, 4'h8, 4'h4, 4'h1, 4'h2, 4'h3, 4'h3, 4'h3, 4'h0, 4'h3, 4'h5,
			4'h3, 4'h6, 4'h7, 4'h9, 4'ha, 4'hb, 4'hc, 4'hd, 4'he, 4'hf, 4'h8, 4'h0};
		idle_send = '{14, 62, 0};
		idle_recv = '{62, 14, 0};

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		button_bits <= '0;
		out_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, then every pattern and the press/hold/release cases
		foreach (directed[i])
			send_tick(directed[i]);
		drain();

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = idle_send[p];
			recv_idle_pct = idle_recv[p];
			for (int b = 0; b < 3; b++) begin
				load_settings(p * 3 + b);
				if (p == 2 && b == 0)
					pressure_armed = 1'b1;
				run_random(120);
				drain();
			end
		end

		// hold one key past the largest debounce count
		load_settings(9);
		repeat (LONG_HOLD) send_tick(4'h2);
		send_tick(4'h0);
		drain();

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: keypad_autorepeat_accel.f
sv/kpar_pkg.sv
sv/kpar_track.sv
sv/keypad_autorepeat_accel.sv
verif/keypad_autorepeat_accel_test.sv
